@@ rtl/adh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_pkg
// shared constants, operation codes and types of the allelic depth histogram
// ----------------------------------------------------------------------------
package adh_pkg;

   localparam int MAX_DEPTH_DEF = 7;
   localparam int KIND_W        = 2;
   localparam int COUNT_W       = 32;
   localparam int TOTAL_W       = 6;
   localparam int BASE_W        = 2;
   localparam int REQ_W         = 8;

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
   localparam logic [OP_W-1:0] OP_BAD   = 3'd3;
   localparam logic [OP_W-1:0] OP_NONE  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [TOTAL_W-1:0] total;
      logic [BASE_W-1:0]  major;
      logic [BASE_W-1:0]  minor;
   } adh_desc_type;

   typedef struct packed {
      logic init_busy;
      logic pop;
   } adh_stat_type;

endpackage

@@ rtl/adh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module adh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/adh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_front
// classifies an accepted beat: range check, bin address, depth sum and alleles
// ----------------------------------------------------------------------------
module adh_front #(
   parameter int MAX_DEPTH = adh_pkg::MAX_DEPTH_DEF
) (
   input  logic                                 accept,
   input  logic [adh_pkg::KIND_W-1:0]           req_kind,
   input  logic [adh_pkg::REQ_W-1:0]            req_count_a,
   input  logic [adh_pkg::REQ_W-1:0]            req_count_c,
   input  logic [adh_pkg::REQ_W-1:0]            req_count_g,
   input  logic [adh_pkg::REQ_W-1:0]            req_count_t,
   output logic                                 push,
   output adh_pkg::adh_desc_type                desc,
   output logic [4*$clog2(MAX_DEPTH+1)-1:0]     addr
);
   import adh_pkg::*;

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

   logic                 bad;
   logic [DEPTH_W-1:0]   d_a, d_c, d_g, d_t;
   logic [BASE_W-1:0]    major, minor;

   function automatic logic [2*BASE_W-1:0] alleles(input logic [DEPTH_W-1:0] d0,
                                                   input logic [DEPTH_W-1:0] d1,
                                                   input logic [DEPTH_W-1:0] d2,
                                                   input logic [DEPTH_W-1:0] d3);
      logic [DEPTH_W-1:0] v [4];
      logic [DEPTH_W-1:0] top;
      logic [DEPTH_W-1:0] low;
      logic [3:0]         eq;
      logic [BASE_W-1:0]  maj;
      logic [BASE_W-1:0]  mnr;
      logic               found;
      v[0] = d0;
      v[1] = d1;
      v[2] = d2;
      v[3] = d3;
      top = '0;
      for (int i = 0; i < 4; i++) begin
         if (v[i] > top) begin
            top = v[i];
         end
      end
      for (int i = 0; i < 4; i++) begin
         eq[i] = (v[i] == top);
      end
      maj = eq[0] ? 2'd0 : eq[1] ? 2'd1 : eq[2] ? 2'd2 : 2'd3;
      mnr = 2'd3;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (eq[i] && (BASE_W'(i) != maj) && !found) begin
            mnr = BASE_W'(i);
            found = 1'b1;
         end
      end
      if (!found) begin
         low = '0;
         for (int i = 0; i < 4; i++) begin
            if (v[i] < top && v[i] > low) begin
               low = v[i];
            end
         end
         mnr = (v[0] == low) ? 2'd0 : (v[1] == low) ? 2'd1 : (v[2] == low) ? 2'd2 : 2'd3;
      end
      return {maj, mnr};
   endfunction

   assign bad = (req_count_a > REQ_W'(MAX_DEPTH)) || (req_count_c > REQ_W'(MAX_DEPTH))
             || (req_count_g > REQ_W'(MAX_DEPTH)) || (req_count_t > REQ_W'(MAX_DEPTH));

   assign d_a = req_count_a[DEPTH_W-1:0];
   assign d_c = req_count_c[DEPTH_W-1:0];
   assign d_g = req_count_g[DEPTH_W-1:0];
   assign d_t = req_count_t[DEPTH_W-1:0];

   assign {major, minor} = alleles(d_a, d_c, d_g, d_t);

   always_comb begin
      push       = accept;
      addr       = {d_a, d_c, d_g, d_t};
      desc.total = TOTAL_W'(d_a) + TOTAL_W'(d_c) + TOTAL_W'(d_g) + TOTAL_W'(d_t);
      desc.major = major;
      desc.minor = minor;
      unique case (req_kind)
         KIND_ADD:   desc.op = bad ? OP_BAD : OP_ADD;
         KIND_READ:  desc.op = bad ? OP_BAD : OP_READ;
         KIND_CLEAR: desc.op = OP_CLEAR;
         default:    desc.op = OP_NONE;
      endcase
   end

endmodule

@@ rtl/adh_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_queue
// two-entry queue of classified beats between front and back
// ----------------------------------------------------------------------------
module adh_queue #(
   parameter int ADDR_W = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  adh_pkg::adh_desc_type push_desc,
   input  logic [ADDR_W-1:0]     push_addr,
   input  logic                  pop,
   output adh_pkg::adh_desc_type head_desc,
   output logic [ADDR_W-1:0]     head_addr,
   output logic                  empty,
   output logic                  full
);
   import adh_pkg::*;

   adh_desc_type      desc_ff [2];
   logic [ADDR_W-1:0] addr_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign head_desc = desc_ff[rd_ptr_ff];
   assign head_addr = addr_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         desc_ff[wr_ptr_ff] <= push_desc;
         addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

endmodule

@@ rtl/adh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adh_back
// executes queued beats against the bin memory and drives the result beat
// ----------------------------------------------------------------------------
module adh_back #(
   parameter int ADDR_W = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  adh_pkg::adh_desc_type         head_desc,
   input  logic [ADDR_W-1:0]             head_addr,
   input  logic                          empty,
   output adh_pkg::adh_stat_type         stat,
   output logic                          rsp_valid,
   output logic [adh_pkg::COUNT_W-1:0]   rsp_bin_count,
   output logic [adh_pkg::TOTAL_W-1:0]   rsp_total_depth,
   output logic [adh_pkg::BASE_W-1:0]    rsp_major_allele,
   output logic [adh_pkg::BASE_W-1:0]    rsp_minor_allele,
   output logic                          rsp_out_of_range
);
   import adh_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ACCESS = 2'd1;
   localparam logic [1:0] ST_CLEAR  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               silent_ff, silent_in;
   adh_desc_type       cur_desc_ff, cur_desc_in;
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [BASE_W-1:0]  rsp_major_ff, rsp_major_in;
   logic [BASE_W-1:0]  rsp_minor_ff, rsp_minor_in;
   logic               rsp_oor_ff, rsp_oor_in;

   logic               wr_en, rd_en, pop;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COUNT_W-1:0] wr_data, rd_data, next_count;

   adh_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (1 << ADDR_W)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_addr),
      .rd_data (rd_data)
   );

   // saturating increment
   assign next_count = (cur_desc_ff.op == OP_ADD && rd_data != '1) ? rd_data + 1'b1 : rd_data;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      silent_in    = silent_ff;
      cur_desc_in  = cur_desc_ff;
      cur_addr_in  = cur_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = '0;
      rsp_total_in = '0;
      rsp_major_in = '0;
      rsp_minor_in = '0;
      rsp_oor_in   = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      pop          = 1'b0;
      wr_addr      = cur_addr_ff;
      wr_data      = next_count;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               unique case (head_desc.op) inside
                  OP_ADD, OP_READ: begin
                     rd_en       = 1'b1;
                     cur_desc_in = head_desc;
                     cur_addr_in = head_addr;
                     state_in    = ST_ACCESS;
                  end
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     silent_in   = 1'b0;
                     state_in    = ST_CLEAR;
                  end
                  OP_BAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_oor_in   = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            wr_en        = (cur_desc_ff.op == OP_ADD);
            rsp_valid_in = 1'b1;
            rsp_count_in = next_count;
            rsp_total_in = cur_desc_ff.total;
            rsp_major_in = cur_desc_ff.major;
            rsp_minor_in = cur_desc_ff.minor;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               rsp_valid_in = !silent_ff;
               silent_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         silent_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_desc_ff  <= cur_desc_in;
      cur_addr_ff  <= cur_addr_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
      rsp_major_ff <= rsp_major_in;
      rsp_minor_ff <= rsp_minor_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign stat.init_busy = silent_ff;
   assign stat.pop       = pop;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_count    = rsp_count_ff;
   assign rsp_total_depth  = rsp_total_ff;
   assign rsp_major_allele = rsp_major_ff;
   assign rsp_minor_allele = rsp_minor_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

@@ rtl/allelic_depth_histogram_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allelic_depth_histogram_top
// four-dimensional histogram of A/C/G/T site depths with saturating bins
//
// a request beat (add, read, clear) is taken when start is high and busy is
// low; every beat yields exactly one result beat, shown for a single cycle
// with rsp_valid high. the receiver cannot stall the result channel.
// the front classifies a beat in its accept cycle and places it in a
// two-entry queue; busy is high while it is full or in the power-up sweep.
// add and read: one bin memory read, then a write back for add; the back
// takes no new beat until that access is done.
// out-of-range and unused kinds: one per cycle in the back while it is idle.
// clear: a sweep over all 2^(4*clog2(MAX_DEPTH+1)) bins of the bin memory
// (4096 at the default), one bin a cycle, then the result beat.
// after reset the same sweep runs with busy held high and no result beat.
// ----------------------------------------------------------------------------
module allelic_depth_histogram_top #(
   parameter int MAX_DEPTH = adh_pkg::MAX_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [adh_pkg::KIND_W-1:0]    req_kind,
   input  logic [adh_pkg::REQ_W-1:0]     req_count_a,
   input  logic [adh_pkg::REQ_W-1:0]     req_count_c,
   input  logic [adh_pkg::REQ_W-1:0]     req_count_g,
   input  logic [adh_pkg::REQ_W-1:0]     req_count_t,
   output logic                          rsp_valid,
   output logic [adh_pkg::COUNT_W-1:0]   rsp_bin_count,
   output logic [adh_pkg::TOTAL_W-1:0]   rsp_total_depth,
   output logic [adh_pkg::BASE_W-1:0]    rsp_major_allele,
   output logic [adh_pkg::BASE_W-1:0]    rsp_minor_allele,
   output logic                          rsp_out_of_range
);
   import adh_pkg::*;

   localparam int ADDR_W = 4 * $clog2(MAX_DEPTH + 1);

   logic              accept, push, q_empty, q_full;
   adh_desc_type      push_desc, head_desc;
   logic [ADDR_W-1:0] push_addr, head_addr;
   adh_stat_type      stat;

   assign busy   = q_full || stat.init_busy;
   assign accept = start && !busy;

   adh_front #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_front (
      .accept      (accept),
      .req_kind    (req_kind),
      .req_count_a (req_count_a),
      .req_count_c (req_count_c),
      .req_count_g (req_count_g),
      .req_count_t (req_count_t),
      .push        (push),
      .desc        (push_desc),
      .addr        (push_addr)
   );

   adh_queue #(
      .ADDR_W (ADDR_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .push_addr (push_addr),
      .pop       (stat.pop),
      .head_desc (head_desc),
      .head_addr (head_addr),
      .empty     (q_empty),
      .full      (q_full)
   );

   adh_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_desc        (head_desc),
      .head_addr        (head_addr),
      .empty            (q_empty),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_total_depth  (rsp_total_depth),
      .rsp_major_allele (rsp_major_allele),
      .rsp_minor_allele (rsp_minor_allele),
      .rsp_out_of_range (rsp_out_of_range)
   );

`ifndef SYNTHESIS
   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      stat.init_busy |-> !rsp_valid)
      else $error("result beat during power-up sweep");

   a_oor_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_bin_count == '0 && rsp_total_depth == '0
         && rsp_major_allele == '0 && rsp_minor_allele == '0))
      else $error("out-of-range result carries data");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> !q_empty)
      else $error("pop from empty queue");
`endif

endmodule
